// ----- rtl/lsdm_pkg.sv -----
`timescale 1ns / 1ps
// Package for the link serialization delay model: widths, register indexes,
// state codes and the word types of the input and output channels.
// Depends on nothing.
package lsdm_pkg;

  localparam int TimeBits  = 48;
  localparam int FracBits  = 16;
  localparam int SizeBits  = 32;
  localparam int SumBits   = 63;
  localparam int CountBits = 32;
  localparam int LoadBits  = 16;
  localparam int CfgBits   = 32;
  localparam int BwBits    = 32;
  localparam int LatBits   = 32;
  localparam int FactBits  = LoadBits + 1;
  localparam int RateBits  = FactBits + BwBits;
  // The quotient saturates when the size reaches the rate shifted by this amount.
  localparam int PreShift  = TimeBits - 16 - FracBits;
  localparam int CntBits   = $clog2(TimeBits + 1);

  localparam logic [FactBits-1:0] LoadOne   = FactBits'(1) << LoadBits;
  localparam logic [BwBits-1:0]   BwReset   = BwBits'(1) << FracBits;
  localparam logic [TimeBits-1:0] TimeMax   = {TimeBits{1'b1}};

  typedef enum logic [1:0] {
    CfgBandwidth = 2'd0,
    CfgLatency   = 2'd1,
    CfgLoad      = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StCheck,
    StDiv,
    StDelay,
    StSend,
    StUpdate,
    StOut
  } state_e;

  typedef struct packed {
    logic                mode;
    logic [TimeBits-1:0] now;
    logic [SizeBits-1:0] pkt_size;
    logic [TimeBits-1:0] saved_free_time;
  } in_word_t;

  typedef struct packed {
    logic [TimeBits-1:0]  send_delay;
    logic [TimeBits-1:0]  prev_free_time;
    logic [SumBits-1:0]   total_size;
    logic [SumBits-1:0]   total_time;
    logic [CountBits-1:0] packet_count;
  } out_word_t;

endpackage

// ----- rtl/link_serialization_delay_model.sv -----
`timescale 1ns / 1ps
// Top level of the link serialization delay model: a FIFO link that turns
// packet words into send delays with a bit-serial multiplier and divider.
// Depends on lsdm_pkg.
//
// Usage: an input word (mode, now, pkt_size, saved_free_time) is taken when
// in_valid_i is high and in_stall_o is low. One output word follows for each
// input word on out_valid_o, held until an edge with out_stall_i low.
// The configuration port writes bandwidth, latency or load on cfg_we_i; it
// should be written only while the block is idle.
// Each word passes from acceptance to its output through the shift-add
// multiplier that forms the rate, one range check, the restoring divider
// (one quotient bit per cycle) and the states for saturating adds, state
// update and output load. A saturated quotient skips the divider. in_stall_o
// stays high for that whole time and drops in the same cycle as the output
// appears, so one word is in work at a time and a new word is taken only
// after the output of the last one is loaded.
// A stalled output holds its word and the next word waits in the final state
// until the output register is free. Reset clears the link free time, the
// totals and the packet count and sets bandwidth to 1.0, latency and load to zero.
module link_serialization_delay_model
  import lsdm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgBits-1:0]  cfg_data_i
);

  state_e state_q, state_d;

  logic [BwBits-1:0]    bandwidth_q;
  logic [LatBits-1:0]   latency_q;
  logic [LoadBits-1:0]  load_q;

  logic [TimeBits-1:0]  free_time_q, free_time_d;
  logic [SumBits-1:0]   size_sum_q, size_sum_d;
  logic [SumBits-1:0]   time_sum_q, time_sum_d;
  logic [CountBits-1:0] packets_q, packets_d;

  in_word_t             item_q, item_d;
  logic [TimeBits-1:0]  prev_q, prev_d;

  logic [RateBits-1:0]  mcand_q, mcand_d;
  logic [FactBits-1:0]  mplier_q, mplier_d;
  logic [RateBits-1:0]  rate_q, rate_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;

  logic [RateBits-1:0]  rem_q, rem_d;
  logic [TimeBits-1:0]  dvd_q, dvd_d;
  logic [TimeBits-1:0]  quo_q, quo_d;

  logic [TimeBits-1:0]  delay_q, delay_d;
  logic [TimeBits-1:0]  wait_q, wait_d;
  logic [TimeBits-1:0]  send_q, send_d;

  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q, out_d;

  logic                 accept;
  logic [RateBits:0]    trial;
  logic [RateBits:0]    trial_diff;
  logic [TimeBits:0]    wide_sum;
  logic [RateBits+PreShift:0] size_ext;
  logic [RateBits+PreShift:0] limit_ext;

  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bandwidth_q <= BwReset;
      latency_q   <= '0;
      load_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBandwidth: bandwidth_q <= cfg_data_i[BwBits-1:0];
        CfgLatency:   latency_q   <= cfg_data_i[LatBits-1:0];
        CfgLoad:      load_q      <= cfg_data_i[LoadBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      free_time_q <= '0;
      size_sum_q  <= '0;
      time_sum_q  <= '0;
      packets_q   <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      free_time_q <= free_time_d;
      size_sum_q  <= size_sum_d;
      time_sum_q  <= time_sum_d;
      packets_q   <= packets_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    prev_q   <= prev_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rate_q   <= rate_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    quo_q    <= quo_d;
    delay_q  <= delay_d;
    wait_q   <= wait_d;
    send_q   <= send_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    free_time_d = free_time_q;
    size_sum_d  = size_sum_q;
    time_sum_d  = time_sum_q;
    packets_d   = packets_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    item_d      = item_q;
    prev_d      = prev_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    rate_d      = rate_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    delay_d     = delay_q;
    wait_d      = wait_q;
    send_d      = send_q;
    out_d       = out_q;

    trial      = {rem_q, dvd_q[TimeBits-1]};
    trial_diff = trial - {1'b0, rate_q};
    wide_sum   = '0;
    size_ext   = {{(RateBits+PreShift+1-SizeBits){1'b0}}, item_q.pkt_size};
    limit_ext  = {1'b0, rate_q, {PreShift{1'b0}}};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          item_d   = in_data_i;
          prev_d   = free_time_q;
          mcand_d  = {{(RateBits-BwBits){1'b0}}, bandwidth_q};
          mplier_d = LoadOne - {1'b0, load_q};
          rate_d   = '0;
          cnt_d    = CntBits'(FactBits - 1);
          state_d  = StMul;
        end
      end
      // One bit of the load factor per cycle, least significant first.
      StMul: begin
        if (mplier_q[0]) begin
          rate_d = rate_q + mcand_q;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - CntBits'(1);
        if (cnt_q == '0) begin
          state_d = StCheck;
        end
      end
      // A zero rate or a quotient that does not fit in the time width saturates.
      // Otherwise the upper quotient bits are zero and the division starts
      // from the upper part of the size.
      StCheck: begin
        if (size_ext >= limit_ext) begin
          quo_d   = TimeMax;
          state_d = StDelay;
        end else begin
          rem_d   = RateBits'(item_q.pkt_size >> PreShift);
          dvd_d   = {item_q.pkt_size[PreShift-1:0], {(TimeBits-PreShift){1'b0}}};
          quo_d   = '0;
          cnt_d   = CntBits'(TimeBits - 1);
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (!trial_diff[RateBits]) begin
          rem_d = trial_diff[RateBits-1:0];
          quo_d = {quo_q[TimeBits-2:0], 1'b1};
        end else begin
          rem_d = trial[RateBits-1:0];
          quo_d = {quo_q[TimeBits-2:0], 1'b0};
        end
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q - CntBits'(1);
        if (cnt_q == '0) begin
          state_d = StDelay;
        end
      end
      StDelay: begin
        wide_sum = {1'b0, quo_q} + {{(TimeBits-LatBits+1){1'b0}}, latency_q};
        delay_d  = wide_sum[TimeBits] ? TimeMax : wide_sum[TimeBits-1:0];
        wait_d   = (free_time_q > item_q.now) ? free_time_q - item_q.now : '0;
        state_d  = StSend;
      end
      StSend: begin
        wide_sum = {1'b0, wait_q} + {1'b0, delay_q};
        if (item_q.mode) begin
          send_d = '0;
        end else begin
          send_d = wide_sum[TimeBits] ? TimeMax : wide_sum[TimeBits-1:0];
        end
        state_d = StUpdate;
      end
      StUpdate: begin
        if (item_q.mode) begin
          free_time_d = item_q.saved_free_time;
          size_sum_d  = size_sum_q - {{(SumBits-SizeBits){1'b0}}, item_q.pkt_size};
          time_sum_d  = time_sum_q - {{(SumBits-TimeBits){1'b0}}, delay_q};
          packets_d   = packets_q - CountBits'(1);
        end else begin
          wide_sum    = {1'b0, item_q.now} + {1'b0, send_q};
          free_time_d = wide_sum[TimeBits] ? TimeMax : wide_sum[TimeBits-1:0];
          size_sum_d  = size_sum_q + {{(SumBits-SizeBits){1'b0}}, item_q.pkt_size};
          time_sum_d  = time_sum_q + {{(SumBits-TimeBits){1'b0}}, delay_q};
          packets_d   = packets_q + CountBits'(1);
        end
        state_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.send_delay     = send_q;
          out_d.prev_free_time = prev_q;
          out_d.total_size     = size_sum_q;
          out_d.total_time     = time_sum_q;
          out_d.packet_count   = packets_q;
          out_valid_d          = 1'b1;
          state_d              = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ----- tb/link_serialization_delay_model_tb.sv -----
`timescale 1ns / 1ps
// Testbench for link_serialization_delay_model: a directed and a random packet
// sequence, an in-bench link delay tracker and a word-by-word output check.
// Depends on lsdm_pkg and the link_serialization_delay_model RTL.
module link_serialization_delay_model_tb;
  import lsdm_pkg::*;

  localparam logic ModeForward  = 1'b0;
  localparam logic ModeRollback = 1'b1;

  typedef struct packed {
    logic [TimeBits-1:0] prev;
    logic [SizeBits-1:0] pkt_size;
  } undo_entry_t;

  class link_delay_checker;
    logic [BwBits-1:0]    bandwidth;
    logic [LatBits-1:0]   latency;
    logic [LoadBits-1:0]  load;
    logic [TimeBits-1:0]  free_at;
    logic [SumBits-1:0]   size_total;
    logic [SumBits-1:0]   delay_total;
    logic [CountBits-1:0] packet_total;
    out_word_t            expected_words[$];
    undo_entry_t          undo_log[$];
    int                   failures;

    function new();
      bandwidth    = BwReset;
      latency      = '0;
      load         = '0;
      free_at      = '0;
      size_total   = '0;
      delay_total  = '0;
      packet_total = '0;
      failures     = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgBits-1:0] value);
      case (idx)
        CfgBandwidth: bandwidth = value;
        CfgLatency:   latency = value;
        CfgLoad:      load = value[LoadBits-1:0];
        default: ;
      endcase
    endfunction

    function logic [TimeBits-1:0] sat_sum(logic [TimeBits-1:0] a, logic [TimeBits-1:0] b);
      logic [TimeBits:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeBits] ? TimeMax : s[TimeBits-1:0];
    endfunction

    function logic [TimeBits-1:0] transfer_delay(logic [SizeBits-1:0] pkt_size);
      logic [RateBits-1:0] rate;
      logic [127:0]        num;
      logic [127:0]        quot;
      logic [TimeBits-1:0] q;
      rate = (RateBits'(LoadOne) - RateBits'(load)) * RateBits'(bandwidth);
      if (rate == '0) begin
        q = TimeMax;
      end else begin
        num  = 128'(pkt_size) << (16 + FracBits);
        quot = num / 128'(rate);
        q    = (quot > 128'(TimeMax)) ? TimeMax : quot[TimeBits-1:0];
      end
      return sat_sum(q, TimeBits'(latency));
    endfunction

    function void note_word(in_word_t w);
      out_word_t           exp_word;
      logic [TimeBits-1:0] delay;
      logic [TimeBits-1:0] backlog;
      exp_word = '0;
      exp_word.prev_free_time = free_at;
      delay = transfer_delay(w.pkt_size);
      if (w.mode == ModeForward) begin
        backlog = (free_at > w.now) ? free_at - w.now : '0;
        exp_word.send_delay = sat_sum(backlog, delay);
        undo_log.push_back('{prev: free_at, pkt_size: w.pkt_size});
        free_at      = sat_sum(w.now, exp_word.send_delay);
        size_total   = size_total + SumBits'(w.pkt_size);
        delay_total  = delay_total + SumBits'(delay);
        packet_total = packet_total + CountBits'(1);
      end else begin
        free_at      = w.saved_free_time;
        size_total   = size_total - SumBits'(w.pkt_size);
        delay_total  = delay_total - SumBits'(delay);
        packet_total = packet_total - CountBits'(1);
      end
      exp_word.total_size   = size_total;
      exp_word.total_time   = delay_total;
      exp_word.packet_count = packet_total;
      expected_words.push_back(exp_word);
    endfunction

    function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
        failures++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_word;
      if (expected_words.size() == 0) begin
        $error("output word with no input word pending: %0h", got);
        failures++;
        return;
      end
      exp_word = expected_words.pop_front();
      compare_field("send_delay", 64'(exp_word.send_delay), 64'(got.send_delay));
      compare_field("prev_free_time", 64'(exp_word.prev_free_time), 64'(got.prev_free_time));
      compare_field("total_size", 64'(exp_word.total_size), 64'(got.total_size));
      compare_field("total_time", 64'(exp_word.total_time), 64'(got.total_time));
      compare_field("packet_count", 64'(exp_word.packet_count), 64'(got.packet_count));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_word_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_data;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CfgBandwidth;
  logic [CfgBits-1:0] cfg_data = '0;

  int                 send_idle = 0;
  int                 recv_stall = 0;
  link_delay_checker  tracker;

  link_serialization_delay_model i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (recv_stall != 0) && ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_word(out_data);
    end
  end

  function automatic in_word_t word_of(logic mode, logic [TimeBits-1:0] now,
                                       logic [SizeBits-1:0] pkt_size,
                                       logic [TimeBits-1:0] saved);
    in_word_t w;
    w.mode            = mode;
    w.now             = now;
    w.pkt_size        = pkt_size;
    w.saved_free_time = saved;
    return w;
  endfunction

  function automatic logic [TimeBits-1:0] rand_time();
    return TimeBits'({$urandom(), $urandom()});
  endfunction

  function automatic logic [SizeBits-1:0] random_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom();
      default: return $urandom_range(0, 32'hF_FFFF);
    endcase
  endfunction

  // Most words are forward packets arriving near the link free time, so the
  // backlog is exercised; rollbacks mostly undo the latest forward packet.
  function automatic in_word_t random_word();
    in_word_t            w;
    undo_entry_t         e;
    logic [TimeBits-1:0] span;
    int                  pick;
    pick = $urandom_range(99);
    span = TimeBits'($urandom_range(0, 32'h10_0000) >> $urandom_range(0, 16));
    w = word_of(ModeForward, tracker.free_at, random_size(), rand_time());
    if (pick < 12 && tracker.undo_log.size() != 0) begin
      e = tracker.undo_log.pop_back();
      w.mode            = ModeRollback;
      w.now             = rand_time();
      w.pkt_size        = e.pkt_size;
      w.saved_free_time = e.prev;
    end else if (pick < 17) begin
      w.mode = ModeRollback;
      w.now  = rand_time();
    end else if (pick < 25) begin
      w.now = rand_time();
    end else if (pick < 60) begin
      w.now = (tracker.free_at > span) ? tracker.free_at - span : '0;
    end else begin
      w.now = tracker.sat_sum(tracker.free_at, span);
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_word(w);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgBits-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    tracker.write_reg(idx, value);
  endtask

  task automatic write_config(logic [BwBits-1:0] bw, logic [LatBits-1:0] lat,
                              logic [LoadBits-1:0] ld);
    write_reg(CfgBandwidth, bw);
    write_reg(CfgLatency, lat);
    write_reg(CfgLoad, CfgBits'(ld));
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (tracker.expected_words.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [BwBits-1:0]   bw;
    logic [LatBits-1:0]  lat;
    logic [LoadBits-1:0] ld;
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the rate is 2^32, so the quotient equals the size.
    send_word(word_of(ModeRollback, '0, 32'd5, '0));
    send_word(word_of(ModeForward, '0, '0, TimeMax));
    send_word(word_of(ModeForward, '0, 32'h1_0000, '0));
    send_word(word_of(ModeForward, '0, 32'h1_0000, '0));
    send_word(word_of(ModeForward, 48'h10_0000, 32'd1, '0));
    send_word(word_of(ModeForward, TimeMax, '1, '0));
    send_word(word_of(ModeForward, '0, '1, '0));
    send_word(word_of(ModeRollback, TimeMax, '1, 48'h1234));
    drain();

    // Zero rate.
    write_config('0, '0, '0);
    send_word(word_of(ModeForward, '0, '0, '0));
    send_word(word_of(ModeForward, 48'd5, '1, '0));
    send_word(word_of(ModeRollback, '0, '0, '0));
    drain();

    // Rate of one: the quotient overflows unless the size is tiny.
    write_config(32'd1, '1, 16'hFFFF);
    send_word(word_of(ModeForward, '0, 32'h0_FFFF, '0));
    send_word(word_of(ModeRollback, '0, 32'h0_FFFF, '0));
    send_word(word_of(ModeForward, '0, 32'h1_0000, '0));
    send_word(word_of(ModeForward, '0, '0, '0));
    send_word(word_of(ModeRollback, '0, '0, '0));
    drain();

    write_config('1, '0, '0);
    send_word(word_of(ModeForward, '0, '1, '0));
    send_word(word_of(ModeForward, '0, 32'd1, '0));
    send_word(word_of(ModeForward, rand_time(), 32'h1234_5678, rand_time()));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 76; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 76; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      case (phase)
        0: begin
          bw = $urandom(); lat = $urandom_range(0, 32'hFFFF); ld = LoadBits'($urandom());
        end
        1: begin bw = '1; lat = '0; ld = '0; end
        2: begin
          bw = $urandom_range(1, 32'hFFFF); lat = '1; ld = LoadBits'($urandom());
        end
        3: begin bw = '0; lat = $urandom(); ld = LoadBits'($urandom()); end
        4: begin bw = BwReset; lat = '0; ld = '1; end
        5: begin bw = $urandom(); lat = $urandom(); ld = LoadBits'($urandom()); end
        6: begin bw = BwReset; lat = $urandom_range(0, 32'hFFF); ld = '0; end
        default: begin
          bw  = $urandom_range(32'h1_0000, 32'h100_0000);
          lat = $urandom_range(0, 1000);
          ld  = LoadBits'($urandom_range(0, 32768));
        end
      endcase
      write_config(bw, lat, ld);
      // A rollback to a small free time first, so a saturated link recovers.
      send_word(word_of(ModeRollback, rand_time(), $urandom(),
                        TimeBits'($urandom_range(0, 32'hF_FFFF))));
      for (int i = 0; i < 124; i++) begin
        send_word(random_word());
      end
      drain();
    end

    if (tracker.expected_words.size() != 0) begin
      $error("%0d output words never arrived", tracker.expected_words.size());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lsdm_pkg.sv
rtl/link_serialization_delay_model.sv
tb/link_serialization_delay_model_tb.sv
